[hw/rtl/jxlcbm_pkg.sv]
// ----------------------------------------------------------------------------
// jxlcbm_pkg
// Shared types and constants for the container box merger: parse phases,
// box type codes, status codes and the fixed 32-byte file prefix.
// ----------------------------------------------------------------------------
`default_nettype none

package jxlcbm_pkg;

    typedef enum logic [2:0] {
        PH_PREFIX,
        PH_FIRST_HDR,
        PH_HDR,
        PH_PAYLOAD,
        PH_AFTER_FINAL,
        PH_FAILED
    } phase_t;

    // Status codes reported in the end-of-file transfer.
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_PREFIX    = 3'd1;
    localparam logic [2:0] ERR_BAD_BOX   = 3'd2;
    localparam logic [2:0] ERR_SEQUENCE  = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED = 3'd4;
    localparam logic [2:0] ERR_TRAILING  = 3'd5;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd6;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [31:0] TYPE_JXLP      = 32'h6a786c70;
    localparam logic [31:0] TYPE_JXLC      = 32'h6a786c63;
    localparam logic [31:0] BOX_HDR_LEN    = 32'd8;
    localparam logic [31:0] JXLP_HDR_LEN   = 32'd12;
    localparam logic [31:0] MAX_CODESTREAM = 32'hfffffff3;

    localparam logic [4:0] PREFIX_LAST   = 5'd31;
    localparam logic [3:0] HDR_SIZE_TYPE = 4'd7;
    localparam logic [3:0] HDR_LAST      = 4'd11;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [31:0] codestream_bytes;
        logic [2:0]  error_code;
        logic        last_result;
    } result_t;

    // Signature box followed by the ftyp box.
    function automatic logic [7:0] prefix_byte(input logic [4:0] idx);
        logic [7:0] val;
        case (idx)
            5'd0:  val = 8'h00;
            5'd1:  val = 8'h00;
            5'd2:  val = 8'h00;
            5'd3:  val = 8'h0c;
            5'd4:  val = 8'h4a;
            5'd5:  val = 8'h58;
            5'd6:  val = 8'h4c;
            5'd7:  val = 8'h20;
            5'd8:  val = 8'h0d;
            5'd9:  val = 8'h0a;
            5'd10: val = 8'h87;
            5'd11: val = 8'h0a;
            5'd12: val = 8'h00;
            5'd13: val = 8'h00;
            5'd14: val = 8'h00;
            5'd15: val = 8'h14;
            5'd16: val = 8'h66;
            5'd17: val = 8'h74;
            5'd18: val = 8'h79;
            5'd19: val = 8'h70;
            5'd20: val = 8'h6a;
            5'd21: val = 8'h78;
            5'd22: val = 8'h6c;
            5'd23: val = 8'h20;
            5'd24: val = 8'h00;
            5'd25: val = 8'h00;
            5'd26: val = 8'h00;
            5'd27: val = 8'h00;
            5'd28: val = 8'h6a;
            5'd29: val = 8'h78;
            5'd30: val = 8'h6c;
            5'd31: val = 8'h20;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/jxl_container_box_merger.sv]
// A byte in the input register is parsed when the result queue has room, and
// its result transfer is then offered from the queue. Throughput: one byte per
// cycle while the queue has room; the end-of-file byte of a payload box yields
// two results, which the four-entry queue drains one per cycle unless stalled.
// Reset (rst_n low, asynchronous) empties both stages and returns the parser to
// the signature check; the parser returns there after every end-of-file status.
// ----------------------------------------------------------------------------
// jxl_container_box_merger
// Byte-serial parser for a boxed image container: checks the fixed prefix,
// follows one jxlc box or a run of jxlp boxes, passes codestream payload out
// and closes each file with a status transfer carrying length and error code.
// ----------------------------------------------------------------------------
`default_nettype none

module jxl_container_box_merger (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_file,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             kind,
    output logic [7:0]       payload_byte,
    output logic [31:0]      codestream_bytes,
    output logic [2:0]       error_code,
    output logic             last_result
);

    // ------------------------------------------------------------------------
    // Input register. A byte waits here until the result queue has room for
    // the two transfers that an end-of-file byte may produce; it then moves
    // into the parser. The stall therefore depends only on registered state
    // and never on the incoming valid.
    // ------------------------------------------------------------------------
    logic        in_full_reg, in_full_next;
    logic [7:0]  in_byte_reg;
    logic        in_eof_reg;
    logic        in_accept;
    logic        advance;

    logic [2:0]  count_reg, count_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [1:0]  wr_ptr_reg, wr_ptr_next;

    assign advance   = in_full_reg && (count_reg <= 3'd2);
    assign in_stall  = in_full_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_accept)
        begin
            in_full_next = 1'b1;
        end
        else if (advance)
        begin
            in_full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg <= in_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= data_byte;
            in_eof_reg  <= end_of_file;
        end
    end

    // ------------------------------------------------------------------------
    // Parser state.
    // ------------------------------------------------------------------------
    jxlcbm_pkg::phase_t phase_reg, phase_next;
    logic [4:0]  prefix_index_reg, prefix_index_next;
    logic [3:0]  hdr_index_reg, hdr_index_next;
    logic [63:0] hdr_bytes_reg, hdr_bytes_next;
    logic [31:0] counter_reg, counter_next;
    logic [31:0] bytes_left_reg, bytes_left_next;
    logic [30:0] next_seq_reg, next_seq_next;
    logic [31:0] total_reg, total_next;
    logic [2:0]  err_reg, err_next;
    logic        final_seen_reg, final_seen_next;

    // Header bytes with the current byte shifted in. After the eighth header
    // byte the upper word is the box size and the lower word the box type.
    logic [63:0] hdr_shift;
    logic [31:0] cnt_shift;
    logic [31:0] new_size;
    logic [31:0] new_type;

    assign hdr_shift = {hdr_bytes_reg[55:0], in_byte_reg};
    assign cnt_shift = {counter_reg[23:0], in_byte_reg};
    assign new_size  = hdr_shift[63:32];
    assign new_type  = hdr_shift[31:0];

    logic        emit;
    logic [2:0]  status_code;
    logic [31:0] status_total;

    always_comb
    begin
        phase_next        = phase_reg;
        prefix_index_next = prefix_index_reg;
        hdr_index_next    = hdr_index_reg;
        hdr_bytes_next    = hdr_bytes_reg;
        counter_next      = counter_reg;
        bytes_left_next   = bytes_left_reg;
        next_seq_next     = next_seq_reg;
        total_next        = total_reg;
        err_next          = err_reg;
        final_seen_next   = final_seen_reg;
        emit              = 1'b0;
        status_code       = jxlcbm_pkg::ERR_NONE;
        status_total      = 32'd0;

        if (advance)
        begin
            case (phase_reg)
                jxlcbm_pkg::PH_PREFIX:
                begin
                    if (in_byte_reg != jxlcbm_pkg::prefix_byte(prefix_index_reg))
                    begin
                        err_next   = jxlcbm_pkg::ERR_PREFIX;
                        phase_next = jxlcbm_pkg::PH_FAILED;
                    end
                    else
                    begin
                        prefix_index_next = prefix_index_reg + 5'd1;
                        if (prefix_index_reg == jxlcbm_pkg::PREFIX_LAST)
                        begin
                            phase_next     = jxlcbm_pkg::PH_FIRST_HDR;
                            hdr_index_next = 4'd0;
                            hdr_bytes_next = 64'd0;
                        end
                    end
                end

                jxlcbm_pkg::PH_FIRST_HDR,
                jxlcbm_pkg::PH_HDR:
                begin
                    hdr_index_next = hdr_index_reg + 4'd1;
                    if (hdr_index_reg < 4'd8)
                    begin
                        hdr_bytes_next = hdr_shift;
                        if (hdr_index_reg == jxlcbm_pkg::HDR_SIZE_TYPE)
                        begin
                            if (phase_reg == jxlcbm_pkg::PH_FIRST_HDR &&
                                new_type == jxlcbm_pkg::TYPE_JXLC)
                            begin
                                if (new_size < jxlcbm_pkg::BOX_HDR_LEN)
                                begin
                                    err_next   = jxlcbm_pkg::ERR_BAD_BOX;
                                    phase_next = jxlcbm_pkg::PH_FAILED;
                                end
                                else
                                begin
                                    // A single jxlc box runs to the end of file.
                                    final_seen_next = 1'b1;
                                    bytes_left_next = new_size - jxlcbm_pkg::BOX_HDR_LEN;
                                    if (new_size == jxlcbm_pkg::BOX_HDR_LEN)
                                    begin
                                        phase_next = jxlcbm_pkg::PH_AFTER_FINAL;
                                    end
                                    else
                                    begin
                                        phase_next = jxlcbm_pkg::PH_PAYLOAD;
                                    end
                                end
                            end
                            else if (new_type != jxlcbm_pkg::TYPE_JXLP ||
                                     new_size < jxlcbm_pkg::JXLP_HDR_LEN)
                            begin
                                err_next   = jxlcbm_pkg::ERR_BAD_BOX;
                                phase_next = jxlcbm_pkg::PH_FAILED;
                            end
                            else
                            begin
                                phase_next = jxlcbm_pkg::PH_HDR;
                            end
                        end
                    end
                    else
                    begin
                        counter_next = cnt_shift;
                        if (hdr_index_reg == jxlcbm_pkg::HDR_LAST)
                        begin
                            if (cnt_shift[30:0] != next_seq_reg)
                            begin
                                err_next   = jxlcbm_pkg::ERR_SEQUENCE;
                                phase_next = jxlcbm_pkg::PH_FAILED;
                            end
                            else
                            begin
                                next_seq_next   = next_seq_reg + 31'd1;
                                final_seen_next = cnt_shift[31];
                                bytes_left_next = hdr_bytes_reg[63:32] -
                                                  jxlcbm_pkg::JXLP_HDR_LEN;
                                if (hdr_bytes_reg[63:32] == jxlcbm_pkg::JXLP_HDR_LEN)
                                begin
                                    // Empty partial box: next header unless final.
                                    if (cnt_shift[31])
                                    begin
                                        phase_next = jxlcbm_pkg::PH_AFTER_FINAL;
                                    end
                                    else
                                    begin
                                        phase_next     = jxlcbm_pkg::PH_HDR;
                                        hdr_index_next = 4'd0;
                                        hdr_bytes_next = 64'd0;
                                        counter_next   = 32'd0;
                                    end
                                end
                                else
                                begin
                                    phase_next = jxlcbm_pkg::PH_PAYLOAD;
                                end
                            end
                        end
                    end
                end

                jxlcbm_pkg::PH_PAYLOAD:
                begin
                    if (total_reg >= jxlcbm_pkg::MAX_CODESTREAM)
                    begin
                        err_next   = jxlcbm_pkg::ERR_OVERFLOW;
                        phase_next = jxlcbm_pkg::PH_FAILED;
                    end
                    else
                    begin
                        emit            = 1'b1;
                        total_next      = total_reg + 32'd1;
                        bytes_left_next = bytes_left_reg - 32'd1;
                        if (bytes_left_reg == 32'd1)
                        begin
                            if (final_seen_reg)
                            begin
                                phase_next = jxlcbm_pkg::PH_AFTER_FINAL;
                            end
                            else
                            begin
                                phase_next     = jxlcbm_pkg::PH_HDR;
                                hdr_index_next = 4'd0;
                                hdr_bytes_next = 64'd0;
                                counter_next   = 32'd0;
                            end
                        end
                    end
                end

                jxlcbm_pkg::PH_AFTER_FINAL:
                begin
                    err_next   = jxlcbm_pkg::ERR_TRAILING;
                    phase_next = jxlcbm_pkg::PH_FAILED;
                end

                default:
                begin
                    // A failed file ignores bytes until the end of file.
                end
            endcase

            if (in_eof_reg)
            begin
                status_total = total_next;
                case (phase_next)
                    jxlcbm_pkg::PH_FAILED:      status_code = err_next;
                    jxlcbm_pkg::PH_AFTER_FINAL: status_code = jxlcbm_pkg::ERR_NONE;
                    jxlcbm_pkg::PH_PREFIX,
                    jxlcbm_pkg::PH_FIRST_HDR:   status_code = jxlcbm_pkg::ERR_PREFIX;
                    default:                    status_code = jxlcbm_pkg::ERR_TRUNCATED;
                endcase

                // The next byte starts a new file.
                phase_next        = jxlcbm_pkg::PH_PREFIX;
                prefix_index_next = 5'd0;
                hdr_index_next    = 4'd0;
                hdr_bytes_next    = 64'd0;
                counter_next      = 32'd0;
                bytes_left_next   = 32'd0;
                next_seq_next     = 31'd0;
                total_next        = 32'd0;
                err_next          = jxlcbm_pkg::ERR_NONE;
                final_seen_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= jxlcbm_pkg::PH_PREFIX;
            prefix_index_reg <= 5'd0;
            hdr_index_reg    <= 4'd0;
            hdr_bytes_reg    <= 64'd0;
            counter_reg      <= 32'd0;
            bytes_left_reg   <= 32'd0;
            next_seq_reg     <= 31'd0;
            total_reg        <= 32'd0;
            err_reg          <= jxlcbm_pkg::ERR_NONE;
            final_seen_reg   <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            prefix_index_reg <= prefix_index_next;
            hdr_index_reg    <= hdr_index_next;
            hdr_bytes_reg    <= hdr_bytes_next;
            counter_reg      <= counter_next;
            bytes_left_reg   <= bytes_left_next;
            next_seq_reg     <= next_seq_next;
            total_reg        <= total_next;
            err_reg          <= err_next;
            final_seen_reg   <= final_seen_next;
        end
    end

    // ------------------------------------------------------------------------
    // Result queue. Four entries; a parsed byte pushes zero, one or two
    // results, and the head entry drives the output ports directly so that a
    // stalled transfer holds its payload.
    // ------------------------------------------------------------------------
    jxlcbm_pkg::result_t queue_reg [4];
    jxlcbm_pkg::result_t payload_res;
    jxlcbm_pkg::result_t status_res;
    jxlcbm_pkg::result_t head;
    logic        push_status;
    logic [1:0]  push_cnt;
    logic        pop;

    assign push_status = advance && in_eof_reg;
    assign push_cnt    = {1'b0, emit} + {1'b0, push_status};

    always_comb
    begin
        payload_res                  = '0;
        payload_res.kind             = jxlcbm_pkg::KIND_PAYLOAD;
        payload_res.payload_byte     = in_byte_reg;

        status_res                   = '0;
        status_res.kind              = jxlcbm_pkg::KIND_STATUS;
        status_res.codestream_bytes  = status_total;
        status_res.error_code        = status_code;
        status_res.last_result       = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            queue_reg[wr_ptr_reg] <= payload_res;
            if (push_status)
            begin
                queue_reg[wr_ptr_reg + 2'd1] <= status_res;
            end
        end
        else if (push_status)
        begin
            queue_reg[wr_ptr_reg] <= status_res;
        end
    end

    assign head      = queue_reg[rd_ptr_reg];
    assign out_valid = (count_reg != 3'd0);
    assign pop       = out_valid && !out_stall;

    assign count_next  = count_reg + {1'b0, push_cnt} - {2'b00, pop};
    assign wr_ptr_next = wr_ptr_reg + push_cnt;
    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 3'd0;
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    assign kind             = head.kind;
    assign payload_byte     = head.payload_byte;
    assign codestream_bytes = head.codestream_bytes;
    assign error_code       = head.error_code;
    assign last_result      = head.last_result;

endmodule

`default_nettype wire

[tb/sv/jxl_container_box_merger_tb.sv]
// ----------------------------------------------------------------------------
// jxl_container_box_merger_tb
// Self-checking bench for the container box merger. Whole container files are
// streamed in one byte per transfer: hand-built files for the corner cases,
// then random well-formed, damaged and garbage files under several sender and
// receiver idling patterns. A scoreboard tracks the parse itself and checks
// every payload and status transfer in order.
// ----------------------------------------------------------------------------
module jxl_container_box_merger_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Counter value flag that marks the last partial box of a file.
    localparam logic [31:0] LAST_BOX_FLAG = 32'h80000000;
    // A box type that the parser must reject.
    localparam logic [31:0] TYPE_FREE     = 32'h66726565;
    // The result path is the input register plus a short queue, so DRAIN_CYCLES
    // covers anything still in flight once the scoreboard is empty.
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 500000;

    // ------------------------------------------------------------------------
    // Scoreboard: follows the container parse byte by byte and keeps the
    // transfers that the block owes us, oldest first.
    // ------------------------------------------------------------------------
    class container_parse_scoreboard;
        logic [7:0]            signature [32];
        jxlcbm_pkg::phase_t    stage;
        int unsigned           sig_pos;
        int unsigned           hdr_count;
        logic [63:0]           hdr_word;
        logic [31:0]           ctr_word;
        logic [31:0]           bytes_to_go;
        logic [30:0]           want_seq;
        logic [31:0]           emitted;
        logic [2:0]            fault;
        bit                    got_final;
        bit                    whole_box;
        jxlcbm_pkg::result_t   owed_q[$];
        int unsigned           fail_count;
        int unsigned           results_checked;
        int unsigned           payload_seen;
        int unsigned           files_closed;
        int unsigned           status_tally [8];

        function new();
            signature = '{8'h00, 8'h00, 8'h00, 8'h0c, 8'h4a, 8'h58, 8'h4c, 8'h20,
                          8'h0d, 8'h0a, 8'h87, 8'h0a,
                          8'h00, 8'h00, 8'h00, 8'h14, 8'h66, 8'h74, 8'h79, 8'h70,
                          8'h6a, 8'h78, 8'h6c, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00,
                          8'h6a, 8'h78, 8'h6c, 8'h20};
            restart();
        endfunction

        function void restart();
            stage       = jxlcbm_pkg::PH_PREFIX;
            sig_pos     = 0;
            hdr_count   = 0;
            hdr_word    = '0;
            ctr_word    = '0;
            bytes_to_go = '0;
            want_seq    = '0;
            emitted     = '0;
            fault       = jxlcbm_pkg::ERR_NONE;
            got_final   = 1'b0;
            whole_box   = 1'b0;
        endfunction

        function void latch_fault(logic [2:0] code);
            fault = code;
            stage = jxlcbm_pkg::PH_FAILED;
        endfunction

        function void close_box();
            if (got_final)
                stage = jxlcbm_pkg::PH_AFTER_FINAL;
            else
            begin
                stage     = jxlcbm_pkg::PH_HDR;
                hdr_count = 0;
                hdr_word  = '0;
                ctr_word  = '0;
            end
        endfunction

        // Advances the parse by one byte; returns 1 when the byte is payload.
        function bit parse_byte(logic [7:0] b);
            logic [31:0] size_field;
            logic [31:0] type_field;
            parse_byte = 1'b0;
            case (stage)
                jxlcbm_pkg::PH_PREFIX:
                begin
                    if (sig_pos >= 32 || b != signature[sig_pos])
                        latch_fault(jxlcbm_pkg::ERR_PREFIX);
                    else
                    begin
                        sig_pos++;
                        if (sig_pos == 32)
                        begin
                            stage     = jxlcbm_pkg::PH_FIRST_HDR;
                            hdr_count = 0;
                            hdr_word  = '0;
                        end
                    end
                end
                jxlcbm_pkg::PH_FIRST_HDR, jxlcbm_pkg::PH_HDR:
                begin
                    if (hdr_count < 8)
                    begin
                        hdr_word = {hdr_word[55:0], b};
                        hdr_count++;
                        if (hdr_count == 8)
                        begin
                            size_field = hdr_word[63:32];
                            type_field = hdr_word[31:0];
                            if (stage == jxlcbm_pkg::PH_FIRST_HDR &&
                                type_field == jxlcbm_pkg::TYPE_JXLC)
                            begin
                                if (size_field < jxlcbm_pkg::BOX_HDR_LEN)
                                    latch_fault(jxlcbm_pkg::ERR_BAD_BOX);
                                else
                                begin
                                    whole_box   = 1'b1;
                                    got_final   = 1'b1;
                                    bytes_to_go = size_field - jxlcbm_pkg::BOX_HDR_LEN;
                                    if (bytes_to_go == 0)
                                        stage = jxlcbm_pkg::PH_AFTER_FINAL;
                                    else
                                        stage = jxlcbm_pkg::PH_PAYLOAD;
                                end
                            end
                            else if (type_field != jxlcbm_pkg::TYPE_JXLP ||
                                     size_field < jxlcbm_pkg::JXLP_HDR_LEN)
                                latch_fault(jxlcbm_pkg::ERR_BAD_BOX);
                            else
                                stage = jxlcbm_pkg::PH_HDR;
                        end
                    end
                    else
                    begin
                        ctr_word = {ctr_word[23:0], b};
                        hdr_count++;
                        if (hdr_count == 12)
                        begin
                            if (ctr_word[30:0] != want_seq)
                                latch_fault(jxlcbm_pkg::ERR_SEQUENCE);
                            else
                            begin
                                want_seq++;
                                got_final   = ctr_word[31];
                                bytes_to_go = hdr_word[63:32] - jxlcbm_pkg::JXLP_HDR_LEN;
                                if (bytes_to_go == 0)
                                    close_box();
                                else
                                    stage = jxlcbm_pkg::PH_PAYLOAD;
                            end
                        end
                    end
                end
                jxlcbm_pkg::PH_PAYLOAD:
                begin
                    if (emitted >= jxlcbm_pkg::MAX_CODESTREAM)
                        latch_fault(jxlcbm_pkg::ERR_OVERFLOW);
                    else
                    begin
                        emitted++;
                        bytes_to_go--;
                        if (bytes_to_go == 0)
                            close_box();
                        parse_byte = 1'b1;
                    end
                end
                jxlcbm_pkg::PH_AFTER_FINAL:
                    latch_fault(jxlcbm_pkg::ERR_TRAILING);
                default:
                    ;
            endcase
        endfunction

        // Called for every accepted input transfer.
        function void note_input(logic [7:0] b, logic eof);
            jxlcbm_pkg::result_t r;
            if (parse_byte(b))
            begin
                r = '0;
                r.kind = jxlcbm_pkg::KIND_PAYLOAD;
                r.payload_byte = b;
                owed_q.insert(owed_q.size(), r);
            end
            if (eof)
            begin
                r = '0;
                r.kind = jxlcbm_pkg::KIND_STATUS;
                r.codestream_bytes = emitted;
                r.last_result = 1'b1;
                if (stage == jxlcbm_pkg::PH_FAILED)
                    r.error_code = fault;
                else if (stage == jxlcbm_pkg::PH_AFTER_FINAL)
                    r.error_code = jxlcbm_pkg::ERR_NONE;
                else if (stage == jxlcbm_pkg::PH_PREFIX ||
                         stage == jxlcbm_pkg::PH_FIRST_HDR)
                    r.error_code = jxlcbm_pkg::ERR_PREFIX;
                else
                    r.error_code = jxlcbm_pkg::ERR_TRUNCATED;
                owed_q.insert(owed_q.size(), r);
                status_tally[r.error_code]++;
                payload_seen += emitted;
                files_closed++;
                restart();
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
                fail_count++;
            end
        endfunction

        // Called for every accepted output transfer.
        function void check_result(jxlcbm_pkg::result_t got);
            jxlcbm_pkg::result_t want;
            if (owed_q.size() == 0)
            begin
                $error("unexpected result transfer: kind %0d, byte 0x%0h, code %0d",
                       got.kind, got.payload_byte, got.error_code);
                fail_count++;
                return;
            end
            want = owed_q.pop_front();
            results_checked++;
            compare_field("kind", 32'(want.kind), 32'(got.kind));
            compare_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
            compare_field("codestream_bytes", want.codestream_bytes, got.codestream_bytes);
            compare_field("error_code", 32'(want.error_code), 32'(got.error_code));
            compare_field("last_result", 32'(want.last_result), 32'(got.last_result));
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block itself.
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n            = 1'b0;
    logic        in_valid         = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte        = 8'h00;
    logic        end_of_file      = 1'b0;
    logic        out_valid;
    logic        out_stall        = 1'b0;
    logic        kind;
    logic [7:0]  payload_byte;
    logic [31:0] codestream_bytes;
    logic [2:0]  error_code;
    logic        last_result;

    // Idling odds in percent; the main sequence changes them per phase.
    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned cycle_count        = 0;

    // Bytes of the file that is being assembled before it is streamed.
    logic [7:0] file_bytes[$];

    container_parse_scoreboard sb = new();

    jxl_container_box_merger u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .data_byte        (data_byte),
        .end_of_file      (end_of_file),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .kind             (kind),
        .payload_byte     (payload_byte),
        .codestream_bytes (codestream_bytes),
        .error_code       (error_code),
        .last_result      (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The receiver stalls at random with the odds of the current phase.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < receiver_stall_pct);

    // Both channels are sampled at the edge where a transfer completes. The
    // input is noted before the output is checked, so the ordering holds even
    // if a result ever came out in the same cycle as its byte.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(data_byte, end_of_file);
            if (out_valid && !out_stall)
                sb.check_result({kind, payload_byte, codestream_bytes, error_code,
                                 last_result});
        end
    end

    // ------------------------------------------------------------------------
    // File builders: each appends to file_bytes.
    // ------------------------------------------------------------------------
    function automatic void add_byte(logic [7:0] b);
        file_bytes.insert(file_bytes.size(), b);
    endfunction

    function automatic void put_signature();
        for (int i = 0; i < 32; i++)
            add_byte(sb.signature[i]);
    endfunction

    function automatic void put_word(logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            add_byte(w[i*8 +: 8]);
    endfunction

    function automatic void put_fill(int n);
        for (int i = 0; i < n; i++)
            add_byte(8'($urandom_range(255)));
    endfunction

    function automatic void put_box(logic [31:0] size_word, logic [31:0] type_word);
        put_word(size_word);
        put_word(type_word);
    endfunction

    // A partial box with random payload; sizes below the header length leave
    // no payload.
    function automatic void put_jxlp(int total_len, logic [31:0] counter);
        put_box(total_len, jxlcbm_pkg::TYPE_JXLP);
        put_word(counter);
        put_fill(total_len - 12);
    endfunction

    // ------------------------------------------------------------------------
    // Driving tasks. The sender always returns at the edge where its byte was
    // taken, so the caller makes exactly one assignment to in_valid there.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic eof);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        data_byte   <= b;
        end_of_file <= eof;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_file();
        int n;
        n = file_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(file_bytes[i], i == n - 1);
        file_bytes.delete();
    endtask

    // Holds the sender off until every owed result has been seen, then lets
    // the pipeline settle.
    task automatic wait_for_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Random files: well-formed containers with random content, damaged
    // containers and plain garbage.
    task automatic run_random_phase(int unsigned idle_pct, int unsigned stall_pct,
                                    int budget);
        int          sent;
        int          pick;
        int          nbox;
        int          mode;
        int          fault_at;
        int          sz;
        int          cut;
        int          idx;
        bit          broken;
        logic [31:0] ctr;
        logic [31:0] btype;
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        sent = 0;
        while (sent < budget)
        begin
            pick   = $urandom_range(99);
            broken = (pick >= 55);
            mode   = $urandom_range(5);
            if (pick < 15)
                put_fill($urandom_range(1, 40));
            else
            begin
                put_signature();
                if ($urandom_range(3) == 0)
                begin
                    // Single codestream box running to the end of the file.
                    sz = 8 + $urandom_range(0, 16);
                    if (broken && mode >= 3)
                        sz = $urandom_range(0, 7);
                    put_box(sz, jxlcbm_pkg::TYPE_JXLC);
                    put_fill(sz - 8);
                end
                else
                begin
                    nbox     = $urandom_range(1, 4);
                    fault_at = $urandom_range(0, nbox - 1);
                    for (int i = 0; i < nbox; i++)
                    begin
                        sz    = 12 + (($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12));
                        ctr   = i;
                        btype = jxlcbm_pkg::TYPE_JXLP;
                        if (i == nbox - 1)
                            ctr |= LAST_BOX_FLAG;
                        if (broken && i == fault_at)
                        begin
                            case (mode)
                                3: ctr = $urandom;
                                4: sz = $urandom_range(0, 11);
                                5: btype = $urandom_range(1) ? jxlcbm_pkg::TYPE_JXLC
                                                             : 32'($urandom);
                                default: ;
                            endcase
                        end
                        put_box(sz, btype);
                        put_word(ctr);
                        put_fill(sz - 12);
                    end
                end
                if (broken)
                begin
                    case (mode)
                        0:
                        begin
                            // Early end of file somewhere in the container.
                            cut = $urandom_range(1, file_bytes.size() - 1);
                            while (file_bytes.size() > cut)
                                void'(file_bytes.pop_back());
                        end
                        1: put_fill($urandom_range(1, 4));
                        2:
                        begin
                            idx = $urandom_range(0, file_bytes.size() - 1);
                            file_bytes[idx] ^= 8'($urandom_range(1, 255));
                        end
                        default: ;
                    endcase
                end
            end
            sent += file_bytes.size();
            send_file();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Hand-built files, no idling on either side.
        // Single codestream box with extreme payload values.
        put_signature();
        put_box(11, jxlcbm_pkg::TYPE_JXLC);
        add_byte(8'h00);
        add_byte(8'hff);
        add_byte(8'h5a);
        send_file();
        // Empty codestream box, and one that is too small.
        put_signature();
        put_box(8, jxlcbm_pkg::TYPE_JXLC);
        send_file();
        put_signature();
        put_box(7, jxlcbm_pkg::TYPE_JXLC);
        send_file();
        // Three partial boxes, the middle one empty.
        put_signature();
        put_jxlp(14, 0);
        put_jxlp(12, 1);
        put_jxlp(13, LAST_BOX_FLAG | 32'd2);
        send_file();
        // A lone empty final box ends the file on its counter.
        put_signature();
        put_jxlp(12, LAST_BOX_FLAG);
        send_file();
        // Signature mismatches at the first and at the last prefix byte; the
        // bytes after the fault are ignored.
        add_byte(8'hff);
        put_fill(5);
        send_file();
        put_signature();
        file_bytes[31] = 8'h21;
        put_jxlp(16, LAST_BOX_FLAG);
        send_file();
        // Short files: one byte, the bare prefix, part of the first header.
        add_byte(8'h00);
        send_file();
        put_signature();
        send_file();
        put_signature();
        put_word(20);
        send_file();
        // End of file inside the first counter counts as truncation.
        put_signature();
        put_box(20, jxlcbm_pkg::TYPE_JXLP);
        add_byte(8'h00);
        send_file();
        // Bad boxes: unknown type, partial box below its header length, and a
        // codestream box after a partial box.
        put_signature();
        put_box(20, TYPE_FREE);
        put_fill(12);
        send_file();
        put_signature();
        put_box(11, jxlcbm_pkg::TYPE_JXLP);
        put_word(0);
        send_file();
        put_signature();
        put_jxlp(13, 0);
        put_box(9, jxlcbm_pkg::TYPE_JXLC);
        put_fill(1);
        send_file();
        // Sequence faults: first counter not zero, all-ones low counter bits.
        put_signature();
        put_jxlp(13, 1);
        send_file();
        put_signature();
        put_jxlp(12, 0);
        put_jxlp(12, 32'h7fffffff);
        send_file();
        // Truncation in a payload, between boxes, and in a later header.
        put_signature();
        put_jxlp(20, LAST_BOX_FLAG);
        repeat (3) void'(file_bytes.pop_back());
        send_file();
        put_signature();
        put_jxlp(14, 0);
        send_file();
        put_signature();
        put_jxlp(13, 0);
        put_word(30);
        send_file();
        // Trailing bytes after a final partial box and after a codestream box.
        put_signature();
        put_jxlp(13, LAST_BOX_FLAG);
        add_byte(8'h00);
        send_file();
        put_signature();
        put_box(8, jxlcbm_pkg::TYPE_JXLC);
        put_fill(3);
        send_file();
        // Largest size field, cut short after a few payload bytes.
        put_signature();
        put_box(32'hffffffff, jxlcbm_pkg::TYPE_JXLP);
        put_word(LAST_BOX_FLAG);
        put_fill(6);
        send_file();

        // Random files under each idling pattern. Between phases the sender
        // holds off until the block has delivered everything it owes.
        wait_for_idle();
        run_random_phase(0, 0, 215);
        wait_for_idle();
        run_random_phase(75, 0, 215);
        wait_for_idle();
        run_random_phase(0, 75, 215);
        wait_for_idle();
        run_random_phase(11, 11, 215);
        wait_for_idle();

        $display("Run covered %0d files, %0d payload bytes, %0d result transfers checked.",
                 sb.files_closed, sb.payload_seen, sb.results_checked);
        $display("Status: ok %0d, prefix %0d, box %0d, seq %0d, trunc %0d, trailing %0d",
                 sb.status_tally[jxlcbm_pkg::ERR_NONE],
                 sb.status_tally[jxlcbm_pkg::ERR_PREFIX],
                 sb.status_tally[jxlcbm_pkg::ERR_BAD_BOX],
                 sb.status_tally[jxlcbm_pkg::ERR_SEQUENCE],
                 sb.status_tally[jxlcbm_pkg::ERR_TRUNCATED],
                 sb.status_tally[jxlcbm_pkg::ERR_TRAILING]);
        if (sb.fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/jxlcbm_pkg.sv
hw/rtl/jxl_container_box_merger.sv
tb/sv/jxl_container_box_merger_tb.sv
